// ===== src/thpsc_pkg.sv =====
`timescale 1ns / 1ps

package thpsc_pkg;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } thpsc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic [16:0]        humidity;
    logic               press_div_zero;
  } thpsc_out_t;

  typedef struct packed {
    logic [31:0] temperature;
    logic [16:0] humidity;
    logic        neg;
    logic        dz;
  } thpsc_side_t;

  localparam int unsigned DivWidth = 64;

  localparam logic [2:0] REG_TEMP      = 3'd0;
  localparam logic [2:0] REG_PRESS_LO  = 3'd1;
  localparam logic [2:0] REG_PRESS_HI  = 3'd2;
  localparam logic [2:0] REG_PRESS_HUM = 3'd3;
  localparam logic [2:0] REG_HUM       = 3'd4;

  localparam logic [63:0] TempOffset  = 64'd128000;
  localparam logic [63:0] PressFull   = 64'd1048576;
  localparam logic [63:0] PressScale  = 64'd3125;
  localparam logic [63:0] PressBias   = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HumOffset   = 32'd76800;
  localparam logic [31:0] HumMax      = 32'd419430400;
  localparam logic [31:0] HumRound    = 32'd16384;
  localparam logic [31:0] HumBase     = 32'd2097152;
  localparam logic [31:0] HumRound2   = 32'd8192;
  localparam logic [31:0] HumUnity    = 32'd32768;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
    return 32'($signed(x) >>> sh);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned sh);
    return 64'($signed(x) >>> sh);
  endfunction

endpackage

// ===== src/thpsc_div.sv =====
`timescale 1ns / 1ps

module thpsc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic [thpsc_pkg::DivWidth-1:0] num_i,
  input  logic [thpsc_pkg::DivWidth-1:0] den_i,
  input  thpsc_pkg::thpsc_side_t         side_i,
  output logic                           vld_o,
  output logic [thpsc_pkg::DivWidth-1:0] quo_o,
  output thpsc_pkg::thpsc_side_t         side_o
);

  localparam int unsigned DW    = thpsc_pkg::DivWidth;
  localparam int unsigned Steps = thpsc_pkg::DivWidth;

  logic [DW-1:0]          rem_q  [Steps];
  logic [DW-1:0]          quo_q  [Steps];
  logic [DW-1:0]          den_q  [Steps];
  thpsc_pkg::thpsc_side_t side_q [Steps];
  logic [Steps-1:0]       vld_q;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [DW-1:0]          rem_in;
    logic [DW-1:0]          quo_in;
    logic [DW-1:0]          den_in;
    thpsc_pkg::thpsc_side_t side_in;
    logic                   vld_in;
    logic [DW:0]            rsh;
    logic                   ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign rsh = {rem_in, quo_in[DW-1]};
    assign ge  = rsh >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DW'(rsh - {1'b0, den_in}) : rsh[DW-1:0];
        quo_q[k]  <= {quo_in[DW-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign quo_o  = quo_q[Steps-1];
  assign side_o = side_q[Steps-1];

endmodule

// ===== src/thp_sensor_compensation.sv =====
`timescale 1ns / 1ps
// Channel    Signals                                   Moves
// input      in_valid_i / in_ready_o / in_data_i      one raw sample request
// output     out_valid_o / out_ready_i / out_data_o   one compensated result
// config     cfg_valid_i / cfg_ready_o / cfg_index_i  one coefficient word
//            / cfg_data_i
// One request enters per cycle while the output is not stalled.
// The pressure path runs through a 64-step restoring divider.
// Reset clears valid bits and coefficients (all zero); payload is not reset.
// A stalled output freezes the whole pipeline; in_ready_o follows that enable.

module thp_sensor_compensation (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  thpsc_pkg::thpsc_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output thpsc_pkg::thpsc_out_t  out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [63:0]            cfg_data_i
);

  logic [47:0] temp_cfg_q;
  logic [63:0] plo_cfg_q;
  logic [63:0] phi_cfg_q;
  logic [47:0] ph_cfg_q;
  logic [31:0] hum_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cfg_q <= '0;
      plo_cfg_q  <= '0;
      phi_cfg_q  <= '0;
      ph_cfg_q   <= '0;
      hum_cfg_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        thpsc_pkg::REG_TEMP:      temp_cfg_q <= cfg_data_i[47:0];
        thpsc_pkg::REG_PRESS_LO:  plo_cfg_q  <= cfg_data_i;
        thpsc_pkg::REG_PRESS_HI:  phi_cfg_q  <= cfg_data_i;
        thpsc_pkg::REG_PRESS_HUM: ph_cfg_q   <= cfg_data_i[47:0];
        thpsc_pkg::REG_HUM:       hum_cfg_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'b0, temp_cfg_q[15:0]};
  assign t2 = {{16{temp_cfg_q[31]}}, temp_cfg_q[31:16]};
  assign t3 = {{16{temp_cfg_q[47]}}, temp_cfg_q[47:32]};
  assign p1 = {48'b0, plo_cfg_q[15:0]};
  assign p2 = {{48{plo_cfg_q[31]}}, plo_cfg_q[31:16]};
  assign p3 = {{48{plo_cfg_q[47]}}, plo_cfg_q[47:32]};
  assign p4 = {{48{plo_cfg_q[63]}}, plo_cfg_q[63:48]};
  assign p5 = {{48{phi_cfg_q[15]}}, phi_cfg_q[15:0]};
  assign p6 = {{48{phi_cfg_q[31]}}, phi_cfg_q[31:16]};
  assign p7 = {{48{phi_cfg_q[47]}}, phi_cfg_q[47:32]};
  assign p8 = {{48{phi_cfg_q[63]}}, phi_cfg_q[63:48]};
  assign p9 = {{48{ph_cfg_q[15]}}, ph_cfg_q[15:0]};
  assign h1 = {24'b0, ph_cfg_q[23:16]};
  assign h2 = {{16{ph_cfg_q[39]}}, ph_cfg_q[39:24]};
  assign h3 = {24'b0, ph_cfg_q[47:40]};
  assign h4 = {{20{hum_cfg_q[11]}}, hum_cfg_q[11:0]};
  assign h5 = {{20{hum_cfg_q[23]}}, hum_cfg_q[23:12]};
  assign h6 = {{24{hum_cfg_q[31]}}, hum_cfg_q[31:24]};

  logic en;
  logic [13:0] pre_v_q;
  logic [5:0]  post_v_q;
  logic        div_vld;
  logic [63:0] div_quo;
  thpsc_pkg::thpsc_side_t div_side;

  assign en          = !post_v_q[5] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = post_v_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q  <= '0;
      post_v_q <= '0;
    end else if (en) begin
      pre_v_q  <= {pre_v_q[12:0], in_valid_i};
      post_v_q <= {post_v_q[4:0], div_vld};
    end
  end

  logic [19:0] s1_rt_q, s1_rp_q;
  logic [15:0] s1_rh_q;
  logic [31:0] s2_a_q, s2_dd_q;
  logic [19:0] s2_rp_q, s3_rp_q, s4_rp_q, s5_rp_q, s6_rp_q, s7_rp_q, s8_rp_q;
  logic [15:0] s2_rh_q, s3_rh_q, s4_rh_q, s5_rh_q, s6_rh_q;
  logic [31:0] s3_va_q, s3_m_q, s4_tf_q;
  logic [31:0] s5_temp_q, s6_temp_q, s7_temp_q, s8_temp_q, s9_temp_q, s10_temp_q;
  logic [31:0] s11_temp_q, s12_temp_q, s13_temp_q;
  logic [63:0] s5_x1_q;
  logic [31:0] s5_v_q;
  logic [63:0] s6_sq_q, s6_x1p5_q, s6_x1p2_q;
  logic [31:0] s6_hv5_q, s6_v6_q, s6_v3_q;
  logic [63:0] s7_x2a_q, s7_x1c_q, s7_x1p5_q, s7_x1p2_q;
  logic [31:0] s7_left_q, s7_in1_q, s7_in2_q;
  logic [63:0] s8_x2_q, s8_x1b_q;
  logic [31:0] s8_hm_q, s8_left_q;
  logic [63:0] s9_m_q, s9_nb_q;
  logic [31:0] s9_r0_q, s9_left_q;
  logic [63:0] s10_den_q, s10_num_q;
  logic [31:0] s10_right_q, s10_left_q;
  logic [63:0] s11_den_q, s11_num_q, s12_den_q, s12_num_q, s13_den_q, s13_num_q;
  logic [31:0] s11_vv_q, s12_vv_q, s12_ss_q, s13_vv_q, s13_t_q;
  logic [63:0] s14_un_q, s14_ud_q;
  thpsc_pkg::thpsc_side_t s14_side_q;
  logic [63:0] s15_p_q, s16_p_q, s16_pp0_q, s16_y2_q, s17_p_q, s17_qq_q, s17_y2_q;
  logic [31:0] s16_pp1_q;
  logic [63:0] s18_y1_q, s18_acc_q, s19_sum_q;
  thpsc_pkg::thpsc_side_t s15_side_q, s16_side_q, s17_side_q, s18_side_q, s19_side_q;
  thpsc_pkg::thpsc_out_t  out_q;

  logic [31:0] rt32, ta, td, hs, hv, hc;
  logic [63:0] q13, pfin, x1s;

  always_comb begin
    rt32 = {12'b0, s1_rt_q};
    ta   = (rt32 >> 3) - (t1 << 1);
    td   = (rt32 >> 4) - t1;
    x1s  = {{31{s5_x1_q[32]}}, s5_x1_q[32:0]};
    hs   = thpsc_pkg::asr32(s11_vv_q, 15);
    hv   = s13_vv_q - thpsc_pkg::asr32(s13_t_q, 4);
    if (hv[31]) begin
      hc = '0;
    end else if (hv > thpsc_pkg::HumMax) begin
      hc = thpsc_pkg::HumMax;
    end else begin
      hc = hv;
    end
    q13  = thpsc_pkg::asr64(s15_p_q, 13);
    pfin = thpsc_pkg::asr64(s19_sum_q, 8) + (p7 << 4);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_rt_q <= in_data_i.raw_temp;
      s1_rp_q <= in_data_i.raw_press;
      s1_rh_q <= in_data_i.raw_hum;

      s2_a_q  <= ta * t2;
      s2_dd_q <= td * td;
      s2_rp_q <= s1_rp_q;
      s2_rh_q <= s1_rh_q;

      s3_va_q <= thpsc_pkg::asr32(s2_a_q, 11);
      s3_m_q  <= thpsc_pkg::asr32(s2_dd_q, 12) * t3;
      s3_rp_q <= s2_rp_q;
      s3_rh_q <= s2_rh_q;

      s4_tf_q <= s3_va_q + thpsc_pkg::asr32(s3_m_q, 14);
      s4_rp_q <= s3_rp_q;
      s4_rh_q <= s3_rh_q;

      s5_temp_q <= thpsc_pkg::asr32(s4_tf_q * 32'd5 + 32'd128, 8);
      s5_x1_q   <= {{32{s4_tf_q[31]}}, s4_tf_q} - thpsc_pkg::TempOffset;
      s5_v_q    <= s4_tf_q - thpsc_pkg::HumOffset;
      s5_rp_q   <= s4_rp_q;
      s5_rh_q   <= s4_rh_q;

      s6_sq_q   <= x1s * x1s;
      s6_x1p5_q <= x1s * p5;
      s6_x1p2_q <= x1s * p2;
      s6_hv5_q  <= h5 * s5_v_q;
      s6_v6_q   <= s5_v_q * h6;
      s6_v3_q   <= s5_v_q * h3;
      s6_temp_q <= s5_temp_q;
      s6_rp_q   <= s5_rp_q;
      s6_rh_q   <= s5_rh_q;

      s7_x2a_q  <= s6_sq_q * p6;
      s7_x1c_q  <= s6_sq_q * p3;
      s7_x1p5_q <= s6_x1p5_q;
      s7_x1p2_q <= s6_x1p2_q;
      s7_left_q <= thpsc_pkg::asr32(({16'b0, s6_rh_q} << 14) - (h4 << 20) - s6_hv5_q
                                    + thpsc_pkg::HumRound, 15);
      s7_in1_q  <= thpsc_pkg::asr32(s6_v6_q, 10);
      s7_in2_q  <= thpsc_pkg::asr32(s6_v3_q, 11) + thpsc_pkg::HumUnity;
      s7_temp_q <= s6_temp_q;
      s7_rp_q   <= s6_rp_q;

      s8_x2_q   <= s7_x2a_q + (s7_x1p5_q << 17) + (p4 << 35);
      s8_x1b_q  <= thpsc_pkg::asr64(s7_x1c_q, 8) + (s7_x1p2_q << 12);
      s8_hm_q   <= s7_in1_q * s7_in2_q;
      s8_left_q <= s7_left_q;
      s8_temp_q <= s7_temp_q;
      s8_rp_q   <= s7_rp_q;

      s9_m_q    <= (thpsc_pkg::PressBias + s8_x1b_q) * p1;
      s9_nb_q   <= ((thpsc_pkg::PressFull - {44'b0, s8_rp_q}) << 31) - s8_x2_q;
      s9_r0_q   <= (thpsc_pkg::asr32(s8_hm_q, 10) + thpsc_pkg::HumBase) * h2;
      s9_left_q <= s8_left_q;
      s9_temp_q <= s8_temp_q;

      s10_den_q   <= thpsc_pkg::asr64(s9_m_q, 33);
      s10_num_q   <= s9_nb_q * thpsc_pkg::PressScale;
      s10_right_q <= thpsc_pkg::asr32(s9_r0_q + thpsc_pkg::HumRound2, 14);
      s10_left_q  <= s9_left_q;
      s10_temp_q  <= s9_temp_q;

      s11_vv_q   <= s10_left_q * s10_right_q;
      s11_den_q  <= s10_den_q;
      s11_num_q  <= s10_num_q;
      s11_temp_q <= s10_temp_q;

      s12_ss_q   <= hs * hs;
      s12_vv_q   <= s11_vv_q;
      s12_den_q  <= s11_den_q;
      s12_num_q  <= s11_num_q;
      s12_temp_q <= s11_temp_q;

      s13_t_q    <= thpsc_pkg::asr32(s12_ss_q, 7) * h1;
      s13_vv_q   <= s12_vv_q;
      s13_den_q  <= s12_den_q;
      s13_num_q  <= s12_num_q;
      s13_temp_q <= s12_temp_q;

      s14_un_q               <= s13_num_q[63] ? (64'd0 - s13_num_q) : s13_num_q;
      s14_ud_q               <= s13_den_q[63] ? (64'd0 - s13_den_q) : s13_den_q;
      s14_side_q.temperature <= s13_temp_q;
      s14_side_q.humidity    <= hc[28:12];
      s14_side_q.neg         <= s13_num_q[63] ^ s13_den_q[63];
      s14_side_q.dz          <= (s13_den_q == 64'd0);

      s15_p_q    <= div_side.neg ? (64'd0 - div_quo) : div_quo;
      s15_side_q <= div_side;

      s16_pp0_q  <= {32'b0, q13[31:0]} * {32'b0, q13[31:0]};
      s16_pp1_q  <= q13[31:0] * q13[63:32];
      s16_y2_q   <= p8 * s15_p_q;
      s16_p_q    <= s15_p_q;
      s16_side_q <= s15_side_q;

      s17_qq_q   <= s16_pp0_q + {s16_pp1_q[30:0], 33'b0};
      s17_y2_q   <= s16_y2_q;
      s17_p_q    <= s16_p_q;
      s17_side_q <= s16_side_q;

      s18_y1_q   <= s17_qq_q * p9;
      s18_acc_q  <= s17_p_q + thpsc_pkg::asr64(s17_y2_q, 19);
      s18_side_q <= s17_side_q;

      s19_sum_q  <= s18_acc_q + thpsc_pkg::asr64(s18_y1_q, 25);
      s19_side_q <= s18_side_q;

      out_q.temperature    <= s19_side_q.temperature;
      out_q.humidity       <= s19_side_q.humidity;
      out_q.press_div_zero <= s19_side_q.dz;
      out_q.pressure       <= s19_side_q.dz ? 32'd0 : pfin[31:0];
    end
  end

  thpsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pre_v_q[13]),
    .num_i  (s14_un_q),
    .den_i  (s14_ud_q),
    .side_i (s14_side_q),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .side_o (div_side)
  );

  assign out_data_o = out_q;

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.press_div_zero |-> out_data_o.pressure == 32'd0)
    else $error("pressure not forced to zero on zero divisor");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.humidity <= 17'd102400)
    else $error("humidity out of range");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

  a_div_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(div_quo) && $stable(div_vld))
    else $error("divider advanced during stall");

endmodule

// ===== tb/thp_sensor_compensation_tb.sv =====
`timescale 1ns / 1ps

module thp_sensor_compensation_tb;

  localparam int unsigned QuietLo = 3000;
  localparam int unsigned QuietHi = 5500;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  thpsc_pkg::thpsc_in_t  in_data;
  logic                  out_valid;
  logic                  out_ready;
  thpsc_pkg::thpsc_out_t out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [2:0]            cfg_index;
  logic [63:0]           cfg_data;

  logic [63:0] cal_temp, cal_plo, cal_phi, cal_ph, cal_hum;
  thpsc_pkg::thpsc_in_t  sample_queue[$];
  thpsc_pkg::thpsc_out_t result_queue[$];
  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;

  thp_sensor_compensation dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit idle_now(int unsigned cyc);
    if (cyc >= QuietLo && cyc < QuietHi) begin
      return 1'b0;
    end
    return $urandom_range(99) < 32;
  endfunction

  function automatic logic [31:0] sx32(logic [15:0] f);
    return {{16{f[15]}}, f};
  endfunction

  function automatic logic [63:0] sx64(logic [15:0] f);
    return {{48{f[15]}}, f};
  endfunction

  function automatic logic [63:0] quot64(logic [63:0] num, logic [63:0] den);
    logic [63:0] un, ud, q;
    un = num[63] ? (64'd0 - num) : num;
    ud = den[63] ? (64'd0 - den) : den;
    q  = un / ud;
    return (num[63] != den[63]) ? (64'd0 - q) : q;
  endfunction

  function automatic thpsc_pkg::thpsc_out_t compensate(thpsc_pkg::thpsc_in_t s);
    thpsc_pkg::thpsc_out_t r;
    logic [31:0] adc_t, adc_h, t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0] a, va, d, m, vb, tfine, v, l, in1, in2, rr, sq, w;
    logic [63:0] adc_p, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] tf64, x1, x2, n, p, q, y1, y2, k;
    adc_t = {12'd0, s.raw_temp};
    adc_p = {44'd0, s.raw_press};
    adc_h = {16'd0, s.raw_hum};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = sx32(cal_temp[31:16]);
    t3 = sx32(cal_temp[47:32]);
    p1 = {48'd0, cal_plo[15:0]};
    p2 = sx64(cal_plo[31:16]);
    p3 = sx64(cal_plo[47:32]);
    p4 = sx64(cal_plo[63:48]);
    p5 = sx64(cal_phi[15:0]);
    p6 = sx64(cal_phi[31:16]);
    p7 = sx64(cal_phi[47:32]);
    p8 = sx64(cal_phi[63:48]);
    p9 = sx64(cal_ph[15:0]);
    h1 = {24'd0, cal_ph[23:16]};
    h2 = sx32(cal_ph[39:24]);
    h3 = {24'd0, cal_ph[47:40]};
    h4 = {{20{cal_hum[11]}}, cal_hum[11:0]};
    h5 = {{20{cal_hum[23]}}, cal_hum[23:12]};
    h6 = {{24{cal_hum[31]}}, cal_hum[31:24]};

    a = ((adc_t >> 3) - (t1 << 1)) * t2;
    va = $signed(a) >>> 11;
    d = (adc_t >> 4) - t1;
    m = d * d;
    m = $signed(m) >>> 12;
    m = m * t3;
    vb = $signed(m) >>> 14;
    tfine = va + vb;
    m = tfine * 32'd5 + 32'd128;
    r.temperature = $signed(m) >>> 8;

    tf64 = {{32{tfine[31]}}, tfine};
    x1 = tf64 - 64'd128000;
    x2 = x1 * x1 * p6;
    k = x1 * p5;
    x2 = x2 + (k << 17);
    x2 = x2 + (p4 << 35);
    k = x1 * x1 * p3;
    k = $signed(k) >>> 8;
    n = x1 * p2;
    x1 = k + (n << 12);
    k = ((64'd1 << 47) + x1) * p1;
    x1 = $signed(k) >>> 33;
    if (x1 == 64'd0) begin
      r.pressure = '0;
      r.press_div_zero = 1'b1;
    end else begin
      p = 64'd1048576 - adc_p;
      n = ((p << 31) - x2) * 64'd3125;
      p = quot64(n, x1);
      q = $signed(p) >>> 13;
      k = p9 * q * q;
      y1 = $signed(k) >>> 25;
      k = p8 * p;
      y2 = $signed(k) >>> 19;
      k = p + y1 + y2;
      k = $signed(k) >>> 8;
      p = k + (p7 << 4);
      r.pressure = p[31:0];
      r.press_div_zero = 1'b0;
    end

    v = tfine - 32'd76800;
    l = (adc_h << 14) - (h4 << 20) - (h5 * v) + 32'd16384;
    l = $signed(l) >>> 15;
    m = v * h6;
    in1 = $signed(m) >>> 10;
    m = v * h3;
    in2 = ($signed(m) >>> 11);
    in2 = in2 + 32'd32768;
    m = in1 * in2;
    rr = $signed(m) >>> 10;
    m = (rr + 32'd2097152) * h2 + 32'd8192;
    rr = $signed(m) >>> 14;
    v = l * rr;
    sq = $signed(v) >>> 15;
    m = sq * sq;
    w = $signed(m) >>> 7;
    m = w * h1;
    w = $signed(m) >>> 4;
    v = v - w;
    if (v[31]) begin
      v = '0;
    end else if (v > 32'd419430400) begin
      v = 32'd419430400;
    end
    m = v >> 12;
    r.humidity = m[16:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // track coefficient writes
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cal_temp <= '0;
      cal_plo  <= '0;
      cal_phi  <= '0;
      cal_ph   <= '0;
      cal_hum  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        thpsc_pkg::REG_TEMP:      cal_temp <= {16'd0, cfg_data[47:0]};
        thpsc_pkg::REG_PRESS_LO:  cal_plo  <= cfg_data;
        thpsc_pkg::REG_PRESS_HI:  cal_phi  <= cfg_data;
        thpsc_pkg::REG_PRESS_HUM: cal_ph   <= {16'd0, cfg_data[47:0]};
        thpsc_pkg::REG_HUM:       cal_hum  <= {32'd0, cfg_data[31:0]};
        default: ;
      endcase
    end
  end

  // request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        result_queue.push_back(compensate(in_data));
      end
      if (!in_valid || in_ready) begin
        if (sample_queue.size() > 0 && !idle_now(cycle_cnt)) begin
          in_valid <= 1'b1;
          in_data  <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_now(cycle_cnt);
    end
  end

  // result monitor
  always @(posedge clk) begin
    thpsc_pkg::thpsc_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) begin
          $display("unexpected result %p", out_data);
        end
      end else begin
        exp_r = result_queue.pop_front();
        if (exp_r.temperature !== out_data.temperature ||
            exp_r.pressure !== out_data.pressure ||
            exp_r.humidity !== out_data.humidity ||
            exp_r.press_div_zero !== out_data.press_div_zero) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10) begin
            $display("mismatch: expected %p actual %p", exp_r, out_data);
          end
        end
      end
    end
  end

  task automatic write_cal(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_typical(logic [15:0] p1);
    write_cal(thpsc_pkg::REG_TEMP, {16'hFC18, 16'd26435, 16'd27504});
    write_cal(thpsc_pkg::REG_PRESS_LO, {16'd2855, 16'd3024, 16'hD643, p1});
    write_cal(thpsc_pkg::REG_PRESS_HI, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
    write_cal(thpsc_pkg::REG_PRESS_HUM, {8'd0, 16'd370, 8'd75, 16'd6000});
    write_cal(thpsc_pkg::REG_HUM, {8'd30, 12'd50, 12'd313});
  endtask

  task automatic write_all(logic [63:0] val);
    write_cal(thpsc_pkg::REG_TEMP, val);
    write_cal(thpsc_pkg::REG_PRESS_LO, val);
    write_cal(thpsc_pkg::REG_PRESS_HI, val);
    write_cal(thpsc_pkg::REG_PRESS_HUM, val);
    write_cal(thpsc_pkg::REG_HUM, val);
  endtask

  task automatic add_sample(logic [19:0] t, logic [19:0] p, logic [15:0] h);
    thpsc_pkg::thpsc_in_t s;
    s.raw_temp  = t;
    s.raw_press = p;
    s.raw_hum   = h;
    sample_queue.push_back(s);
  endtask

  task automatic add_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 60) begin
        add_sample(20'($urandom_range(600000, 400000)),
                   20'($urandom_range(500000, 250000)),
                   16'($urandom_range(45000, 20000)));
      end else begin
        add_sample(20'($urandom), 20'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic drain();
    while (sample_queue.size() > 0 || in_valid || result_queue.size() > 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic add_directed();
    add_sample(20'd519888, 20'd415148, 16'd30000);
    add_sample(20'd0, 20'd0, 16'd0);
    add_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    add_sample(20'd0, 20'hFFFFF, 16'hFFFF);
    add_sample(20'hFFFFF, 20'd0, 16'd0);
    add_sample(20'd519888, 20'd0, 16'hFFFF);
    add_sample(20'd519888, 20'hFFFFF, 16'd0);
    add_sample(20'h80000, 20'h80000, 16'h8000);
    add_sample(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
    add_sample(20'd440064, 20'd300000, 16'd42000);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cycle_cnt = 0;
    mismatch_cnt = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_directed();
    add_random(40);
    drain();

    write_typical(16'd36477);
    add_directed();
    add_random(300);
    drain();

    write_all('1);
    add_directed();
    add_random(200);
    drain();

    write_all(64'h7FFF_7FFF_7FFF_7FFF);
    add_random(200);
    drain();

    write_typical(16'd0);
    add_directed();
    add_random(150);
    drain();

    write_all(64'h8000_8000_8000_8000);
    add_random(150);
    drain();

    for (int i = 0; i < 3; i++) begin
      write_cal(thpsc_pkg::REG_TEMP, {$urandom, $urandom});
      write_cal(thpsc_pkg::REG_PRESS_LO, {$urandom, $urandom});
      write_cal(thpsc_pkg::REG_PRESS_HI, {$urandom, $urandom});
      write_cal(thpsc_pkg::REG_PRESS_HUM, {$urandom, $urandom});
      write_cal(thpsc_pkg::REG_HUM, {$urandom, $urandom});
      for (logic [3:0] j = {1'b0, thpsc_pkg::REG_HUM} + 4'd1; j <= 4'd7; j++) begin
        write_cal(j[2:0], {$urandom, $urandom});
      end
      add_random(180);
      drain();
    end

    write_all('0);
    add_directed();
    add_random(40);
    drain();

    if (mismatch_cnt == 0 && result_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
